/* design/pso_pkg.sv */
package pso_pkg;

   localparam int STAGES_DEF = 3;

   localparam int CMD_W      = 2;
   localparam int TIME_W     = 62;
   localparam int WORD_W     = 64;
   localparam int ASYM_W     = 21;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;
   localparam int PROD_W     = 2 * WORD_W;

   // interval divider: 64 quotient bits, DIV_STEP per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = WORD_W / DIV_STEP;
   localparam int REM_W      = 30;
   localparam int EL_LO_W    = 16;

   localparam logic [REM_W-1:0]  NS_PER_S  = 30'd1000000000;
   // 65536 s in ns: Ta would no longer fit Q16.48
   localparam logic [TIME_W-1:0] TA_SAT_NS = 62'd65536000000000;

   localparam logic [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [GAIN_W-1:0] GAIN0_RST = 16'd256;
   localparam logic [GAIN_W-1:0] GAIN1_RST = 16'd3200;
   localparam logic [GAIN_W-1:0] GAIN2_RST = 16'd6400;

   typedef enum logic [CMD_W-1:0] {
      CMD_SYNC     = 2'd0,
      CMD_REQ_SENT = 2'd1,
      CMD_RESPONSE = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_ASYM   = 3'd1,
      CSR_GAIN0  = 3'd2,
      CSR_GAIN1  = 3'd3,
      CSR_GAIN2  = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_NEGATE,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_TERM_MUL,
      ST_TERM_WAIT,
      ST_TERM_ADD,
      ST_GAIN_MUL,
      ST_GAIN_WAIT,
      ST_GAIN_ADD,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
      logic gain_mode;   // 1: shift 8 (gain), 0: shift 48 (Ta)
   } mul_ctl_type;

   function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         sat_add = s[WORD_W] ? S64_MIN : S64_MAX;
      end else begin
         sat_add = s[WORD_W-1:0];
      end
   endfunction

   function automatic logic [WORD_W-1:0] sat_neg(input logic [WORD_W-1:0] a);
      sat_neg = (a == S64_MIN) ? S64_MAX : (~a + 1'b1);
   endfunction

endpackage

/* design/pso_ta_div.sv */
module pso_ta_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pso_pkg::TIME_W-1:0] elapsed,
   output logic                       done,
   output logic [pso_pkg::WORD_W-1:0] ta
);
   import pso_pkg::*;

   // restoring division of elapsed * 2^48 by 1e9, DIV_STEP quotient bits a cycle
   localparam int CNT_W = $clog2(DIV_CYCLES);

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [EL_LO_W-1:0] sh_ff, sh_in;
   logic [WORD_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               sat_ff, sat_in;

   logic [REM_W-1:0]    div_r;
   logic [REM_W:0]      div_t;
   logic [DIV_STEP-1:0] div_q;

   always_comb begin
      div_r = rem_ff;
      div_t = '0;
      div_q = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
         div_t = {div_r, sh_ff[EL_LO_W-1-j]};
         if (div_t >= {1'b0, NS_PER_S}) begin
            div_t = div_t - {1'b0, NS_PER_S};
            div_q[DIV_STEP-1-j] = 1'b1;
         end
         div_r = div_t[REM_W-1:0];
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = elapsed[EL_LO_W+REM_W-1:EL_LO_W];
         sh_in   = elapsed[EL_LO_W-1:0];
         sat_in  = (elapsed >= TA_SAT_NS);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = div_r;
         sh_in  = {sh_ff[EL_LO_W-DIV_STEP-1:0], {DIV_STEP{1'b0}}};
         q_in   = {q_ff[WORD_W-DIV_STEP-1:0], div_q};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign ta   = sat_ff ? {WORD_W{1'b1}} : q_ff;

endmodule

/* design/pso_mul.sv */
module pso_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  pso_pkg::mul_ctl_type        ctl,
   input  logic [pso_pkg::WORD_W-1:0]  op_a,
   input  logic [pso_pkg::WORD_W-1:0]  op_b,
   output logic                        done,
   output logic [pso_pkg::WORD_W-1:0]  result
);
   import pso_pkg::*;

   // signed op_a times unsigned op_b via four 32x32 partial products,
   // then shift, truncate toward zero and saturate
   localparam int HALF_W = WORD_W / 2;
   localparam logic [2:0] LAST_STEP = 3'd5;

   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic              neg_ff, neg_in;
   logic              mode_ff, mode_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] pp_ff, pp_in;
   logic [2:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] res_ff, res_in;

   logic [HALF_W-1:0] x_half, b_half;
   logic [PROD_W-1:0] r_full;
   logic [WORD_W-1:0] lim, mag;
   logic              ovf;

   always_comb begin
      x_half = (step_ff == 3'd2 || step_ff == 3'd3) ? x_ff[WORD_W-1:HALF_W]
                                                    : x_ff[HALF_W-1:0];
      b_half = (step_ff == 3'd1 || step_ff == 3'd3) ? b_ff[WORD_W-1:HALF_W]
                                                    : b_ff[HALF_W-1:0];
      pp_in  = x_half * b_half;

      r_full = mode_ff ? (acc_ff >> 8) : (acc_ff >> 48);
      lim    = neg_ff ? S64_MIN : S64_MAX;
      ovf    = (|r_full[PROD_W-1:WORD_W]) || (r_full[WORD_W-1:0] > lim);
      mag    = ovf ? lim : r_full[WORD_W-1:0];
   end

   always_comb begin
      x_in    = x_ff;
      b_in    = b_ff;
      neg_in  = neg_ff;
      mode_in = mode_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         neg_in  = op_a[WORD_W-1];
         x_in    = op_a[WORD_W-1] ? (~op_a + 1'b1) : op_a;
         b_in    = op_b;
         mode_in = ctl.gain_mode;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         // add the product registered in the previous step
         case (step_ff)
            3'd1:      acc_in = acc_ff + {{WORD_W{1'b0}}, pp_ff};
            3'd2,
            3'd3:      acc_in = acc_ff + {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
            3'd4:      acc_in = acc_ff + {pp_ff, {WORD_W{1'b0}}};
            default:   acc_in = acc_ff;
         endcase
         if (step_ff == LAST_STEP) begin
            res_in  = neg_ff ? (~mag + 1'b1) : mag;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      mode_ff <= mode_in;
      acc_ff  <= acc_in;
      pp_ff   <= pp_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* design/ptp_slave_offset_servo_core.sv */
// Sync and delay-request-sent words: stored on acceptance, ready again the next cycle.
// Delay-response word: in accumulation mode the offset is negated and added to the
// accumulator; with the integrator cascade the interval divider runs first, then five
// passes (with three stages) go through the shared 32x32 multiplier for terms and gains.
// One word is in work at a time; a finished result may wait while the next is taken.
// Synchronous active-high reset clears the state kept across words and loads the default gains.
module ptp_slave_offset_servo_core #(
   parameter int STAGES = pso_pkg::STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pso_pkg::CMD_W-1:0]          req_command,
   input  logic [pso_pkg::TIME_W-1:0]         req_master_time_ns,
   input  logic [pso_pkg::TIME_W-1:0]         req_slave_time_ns,
   input  logic [pso_pkg::TIME_W-1:0]         req_now_ns,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pso_pkg::WORD_W-1:0]  rsp_clock_correction,
   output logic signed [pso_pkg::WORD_W-1:0]  rsp_offset_estimate,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pso_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pso_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pso_pkg::*;

   localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

   state_type          state_ff, state_in;
   logic               en_ff;
   logic [ASYM_W-1:0]  asym_ff;
   logic [GAIN_W-1:0]  gain_ff [3];

   logic [WORD_W-1:0]  msd_ff, msd_in;
   logic [TIME_W-1:0]  rst_ff, rst_in;
   logic [TIME_W-1:0]  tm_ff, tm_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [TIME_W-1:0]  el_ff, el_in;
   logic [WORD_W-1:0]  off_ff, off_in;
   logic [WORD_W-1:0]  negoff_ff, negoff_in;
   logic [WORD_W-1:0]  accum_ff, accum_in;
   logic [WORD_W-1:0]  corr_ff, corr_in;
   logic [WORD_W-1:0]  ta_ff, ta_in;
   logic [WORD_W-1:0]  terms_ff [STAGES];
   logic [WORD_W-1:0]  terms_in [STAGES];
   logic [STG_W-1:0]   stage_ff, stage_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_corr_ff, rsp_corr_in;
   logic [WORD_W-1:0]  rsp_off_ff, rsp_off_in;

   logic               req_fire;
   logic [WORD_W-1:0]  sm;
   logic [WORD_W+1:0]  d_full;
   logic               pos_ovf, neg_ovf;
   logic [STG_W-1:0]   rd_idx;
   logic [WORD_W-1:0]  term_rd;
   logic [GAIN_W-1:0]  gain_sel;

   mul_ctl_type        mul_ctl;
   logic [WORD_W-1:0]  mul_b;
   logic               mul_done;
   logic [WORD_W-1:0]  mul_res;
   logic               div_start;
   logic               div_done;
   logic [WORD_W-1:0]  div_ta;

   pso_ta_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .elapsed (el_ff),
      .done    (div_done),
      .ta      (div_ta)
   );

   pso_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .op_a   (term_rd),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= 1'b0;
         asym_ff    <= '0;
         gain_ff[0] <= GAIN0_RST;
         gain_ff[1] <= GAIN1_RST;
         gain_ff[2] <= GAIN2_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: en_ff      <= csr_data[0];
            CSR_ASYM:   asym_ff    <= csr_data[ASYM_W-1:0];
            CSR_GAIN0:  gain_ff[0] <= csr_data[GAIN_W-1:0];
            CSR_GAIN1:  gain_ff[1] <= csr_data[GAIN_W-1:0];
            CSR_GAIN2:  gain_ff[2] <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath helpers
   always_comb begin
      sm = {2'b00, tm_ff} - {2'b00, rst_ff};
      d_full = {{2{msd_ff[WORD_W-1]}}, msd_ff}
             - {{(WORD_W+2-ASYM_W){asym_ff[ASYM_W-1]}}, asym_ff}
             - {{2{sm[WORD_W-1]}}, sm};
      // offset = d * 2^15, saturated; fits only for -2^48 <= d < 2^48
      pos_ovf = !d_full[WORD_W+1] && (|d_full[WORD_W:48]);
      neg_ovf = d_full[WORD_W+1] && !(&d_full[WORD_W:48]);

      rd_idx  = (state_ff == ST_TERM_MUL) ? (stage_ff - 1'b1) : stage_ff;
      term_rd = terms_ff[rd_idx];

      if (stage_ff == STG_W'(0)) begin
         gain_sel = gain_ff[0];
      end else if (stage_ff == STG_W'(1)) begin
         gain_sel = gain_ff[1];
      end else begin
         gain_sel = gain_ff[2];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      msd_in       = msd_ff;
      rst_in       = rst_ff;
      tm_in        = tm_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      el_in        = el_ff;
      off_in       = off_ff;
      negoff_in    = negoff_ff;
      accum_in     = accum_ff;
      corr_in      = corr_ff;
      ta_in        = ta_ff;
      terms_in     = terms_ff;
      stage_in     = stage_ff;
      rsp_corr_in  = rsp_corr_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_ctl      = '{start: 1'b0, gain_mode: 1'b0};
      mul_b        = ta_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tm_in  = req_master_time_ns;
               now_in = req_now_ns;
               case (req_command)
                  CMD_SYNC:     msd_in   = {2'b00, req_slave_time_ns}
                                         - {2'b00, req_master_time_ns};
                  CMD_REQ_SENT: rst_in   = req_slave_time_ns;
                  CMD_RESPONSE: state_in = ST_OFFSET;
                  default: ;
               endcase
            end
         end
         ST_OFFSET: begin
            if (pos_ovf) begin
               off_in = S64_MAX;
            end else if (neg_ovf) begin
               off_in = S64_MIN;
            end else begin
               off_in = {d_full[48:0], 15'd0};
            end
            el_in    = (now_ff >= last_ff) ? (now_ff - last_ff) : '0;
            state_in = ST_NEGATE;
         end
         ST_NEGATE: begin
            negoff_in = sat_neg(off_ff);
            corr_in   = '0;
            state_in  = en_ff ? ST_DIV_START : ST_ACCUM;
         end
         ST_ACCUM: begin
            accum_in = sat_add(accum_ff, negoff_ff);
            corr_in  = sat_add(accum_ff, negoff_ff);
            state_in = ST_RESULT;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            last_in   = now_ff;
            stage_in  = STG_W'(STAGES - 1);
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               ta_in    = div_ta;
               state_in = (stage_ff == '0) ? ST_TERM_ADD : ST_TERM_MUL;
            end
         end
         ST_TERM_MUL: begin
            // stage below, still holding its value from before this update
            mul_ctl  = '{start: 1'b1, gain_mode: 1'b0};
            mul_b    = ta_ff;
            state_in = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            if (mul_done) begin
               state_in = ST_TERM_ADD;
            end
         end
         ST_TERM_ADD: begin
            if (stage_ff == '0) begin
               terms_in[stage_ff] = negoff_ff;
            end else begin
               terms_in[stage_ff] = sat_add(term_rd, mul_res);
            end
            state_in = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            mul_ctl  = '{start: 1'b1, gain_mode: 1'b1};
            mul_b    = {{(WORD_W-GAIN_W){1'b0}}, gain_sel};
            state_in = ST_GAIN_WAIT;
         end
         ST_GAIN_WAIT: begin
            if (mul_done) begin
               state_in = ST_GAIN_ADD;
            end
         end
         ST_GAIN_ADD: begin
            corr_in = sat_add(corr_ff, mul_res);
            if (stage_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               stage_in = stage_ff - 1'b1;
               state_in = (stage_ff == STG_W'(1)) ? ST_TERM_ADD : ST_TERM_MUL;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_corr_in  = corr_ff;
               rsp_off_in   = off_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         msd_ff       <= '0;
         rst_ff       <= '0;
         last_ff      <= '0;
         accum_ff     <= '0;
         stage_ff     <= '0;
         for (int i = 0; i < STAGES; i++) begin
            terms_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         msd_ff       <= msd_in;
         rst_ff       <= rst_in;
         last_ff      <= last_in;
         accum_ff     <= accum_in;
         stage_ff     <= stage_in;
         terms_ff     <= terms_in;
      end
      tm_ff       <= tm_in;
      now_ff      <= now_in;
      el_ff       <= el_in;
      off_ff      <= off_in;
      negoff_ff   <= negoff_in;
      corr_ff     <= corr_in;
      ta_ff       <= ta_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_off_ff  <= rsp_off_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_clock_correction = rsp_corr_ff;
   assign rsp_offset_estimate  = rsp_off_ff;

endmodule

/* design/pso_checker.sv */
module pso_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [pso_pkg::CMD_W-1:0]          req_command,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pso_pkg::WORD_W-1:0]  rsp_clock_correction,
   input logic signed [pso_pkg::WORD_W-1:0]  rsp_offset_estimate
);
   import pso_pkg::*;

   // block comes out of reset able to take a word
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

   // a delay response occupies the servo for at least the next cycle
   a_response_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_RESPONSE) |=> !req_ready)
      else $error("ready high straight after a delay response");

   // sync and request-sent words are only stored; the block is ready again in the next cycle
   a_store_quick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command != CMD_RESPONSE) |=> req_ready)
      else $error("ready dropped after a store-only word");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_clock_correction)
                                     && $stable(rsp_offset_estimate)))
      else $error("result changed while stalled");

endmodule

bind ptp_slave_offset_servo_core pso_checker u_pso_checker (.*);

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pso_pkg::*;

   localparam int     CLK_HALF_NS     = 4;
   localparam int     RESET_CYCLES    = 8;
   localparam int     SETTLE_CYCLES   = 100;
   localparam int     WATCHDOG_LIMIT  = 2000;
   localparam int     WORDS_PER_SETUP = 111;
   localparam int     STAGE_COUNT     = STAGES_DEF;
   localparam int     ASYM_LIMIT      = 1000000;
   localparam int     CSR_SPARE_LO    = int'(CSR_GAIN2) + 1;
   localparam int     CSR_SPARE_HI    = (1 << CSR_IDX_W) - 1;

   localparam longint S_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S_MIN        = 64'sh8000_0000_0000_0000;
   localparam longint OFFSET_D_MAX = (64'sd1 <<< 48) - 1;
   localparam longint OFFSET_D_MIN = -(64'sd1 <<< 48);

   localparam logic [TIME_W-1:0] TIME_MAX    = '1;
   localparam logic [TIME_W-1:0] TA_LIMIT_NS = 62'd65536000000000;

   typedef struct packed {
      logic signed [WORD_W-1:0] correction;
      logic signed [WORD_W-1:0] offset;
   } servo_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = '0;
   logic [TIME_W-1:0]          req_master_time_ns = '0;
   logic [TIME_W-1:0]          req_slave_time_ns = '0;
   logic [TIME_W-1:0]          req_now_ns = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]   rsp_clock_correction;
   logic signed [WORD_W-1:0]   rsp_offset_estimate;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // servo state as predicted
   bit                         ctl_enable;
   longint                     asym_ns;
   logic [GAIN_W-1:0]          stage_gain [0:2];
   longint                     ms_delay_ns;
   logic [TIME_W-1:0]          t3_ns;
   longint                     stage_terms [0:2];
   logic [TIME_W-1:0]          last_fix_ns;
   longint                     acc_correction;

   servo_result_type           expected_corrections [$];
   logic [TIME_W-1:0]          local_clock_ns = '0;
   int                         tx_idle_pct = 32;
   int                         rx_stall_pct = 68;
   int                         errors = 0;
   int                         words_sent = 0;
   int                         corrections_checked = 0;
   int                         settings_applied = 0;
   int                         idle_cycles = 0;

   ptp_slave_offset_servo_core uut (.*);

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // ---------------------------------------------------------------- arithmetic

   function automatic longint add_sat(input longint a, input longint b);
      if (b > 0 && a > S_MAX - b) return S_MAX;
      if (b < 0 && a < S_MIN - b) return S_MIN;
      return a + b;
   endfunction

   function automatic longint sub_sat(input longint a, input longint b);
      if (b < 0 && a > S_MAX + b) return S_MAX;
      if (b > 0 && a < S_MIN + b) return S_MIN;
      return a - b;
   endfunction

   function automatic longint neg_sat(input longint a);
      return (a == S_MIN) ? S_MAX : -a;
   endfunction

   // signed times unsigned, shifted down, truncated toward zero, clamped
   function automatic longint scale_mul(input longint a, input logic [WORD_W-1:0] b,
                                        input int sh);
      logic                  neg;
      logic [WORD_W-1:0]     mag;
      logic [WORD_W-1:0]     lim;
      logic [PROD_W-1:0]     p;
      neg = (a < 0);
      mag = neg ? WORD_W'(-a) : WORD_W'(a);
      p   = mag * b;
      p   = p >> sh;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (p > {64'd0, lim}) p = {64'd0, lim};
      return neg ? -$signed(p[WORD_W-1:0]) : $signed(p[WORD_W-1:0]);
   endfunction

   // elapsed ns to seconds in Q16.48
   function automatic logic [WORD_W-1:0] interval_q48(input logic [TIME_W-1:0] el);
      logic [PROD_W-1:0] num;
      if (el >= TA_LIMIT_NS) return '1;
      num = PROD_W'(el) << 48;
      return WORD_W'(num / 128'd1000000000);
   endfunction

   // ---------------------------------------------------------------- prediction

   function automatic void servo_reset();
      ctl_enable     = 1'b0;
      asym_ns        = 0;
      stage_gain[0]  = GAIN0_RST;
      stage_gain[1]  = GAIN1_RST;
      stage_gain[2]  = GAIN2_RST;
      ms_delay_ns    = 0;
      t3_ns          = '0;
      stage_terms    = '{0, 0, 0};
      last_fix_ns    = '0;
      acc_correction = 0;
   endfunction

   function automatic void register_write(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE: ctl_enable = data[0];
         CSR_ASYM:   asym_ns = $signed(data[ASYM_W-1:0]);
         CSR_GAIN0:  stage_gain[0] = data[GAIN_W-1:0];
         CSR_GAIN1:  stage_gain[1] = data[GAIN_W-1:0];
         CSR_GAIN2:  stage_gain[2] = data[GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void servo_update(input cmd_type cmd,
                                        input logic [TIME_W-1:0] master_ns,
                                        input logic [TIME_W-1:0] slave_ns,
                                        input logic [TIME_W-1:0] now_ns);
      longint              sm, d, off, corr;
      logic [TIME_W-1:0]   el;
      logic [WORD_W-1:0]   ta;
      servo_result_type    res;
      int                  i;
      corr = 0;
      case (cmd)
         CMD_SYNC: begin
            ms_delay_ns = $signed({2'b00, slave_ns}) - $signed({2'b00, master_ns});
         end
         CMD_REQ_SENT: begin
            t3_ns = slave_ns;
         end
         CMD_RESPONSE: begin
            sm = $signed({2'b00, master_ns}) - $signed({2'b00, t3_ns});
            d  = sub_sat(sub_sat(ms_delay_ns, asym_ns), sm);
            // halving and the move to Q.16 fold into one scale of 2^15
            if (d > OFFSET_D_MAX) off = S_MAX;
            else if (d < OFFSET_D_MIN) off = S_MIN;
            else off = d * 64'sd32768;
            if (ctl_enable) begin
               el = (now_ns >= last_fix_ns) ? now_ns - last_fix_ns : '0;
               ta = interval_q48(el);
               last_fix_ns = now_ns;
               // top stage first so each stage sees the old value below it
               for (i = STAGE_COUNT - 1; i >= 0; i--) begin
                  if (i == 0) stage_terms[0] = neg_sat(off);
                  else stage_terms[i] = add_sat(stage_terms[i],
                                                scale_mul(stage_terms[i-1], ta, 48));
                  corr = add_sat(corr, scale_mul(stage_terms[i],
                                                 WORD_W'(stage_gain[i]), 8));
               end
            end else begin
               acc_correction = add_sat(acc_correction, neg_sat(off));
               corr = acc_correction;
            end
            res.correction = corr;
            res.offset     = off;
            expected_corrections.insert(expected_corrections.size(), res);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      servo_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         corrections_checked++;
         if (expected_corrections.size() == 0) begin
            $display("%0t: unexpected result word, correction %0d offset %0d", $time,
                     rsp_clock_correction, rsp_offset_estimate);
            errors++;
         end else begin
            want = expected_corrections.pop_front();
            if (rsp_clock_correction !== want.correction) begin
               $display("%0t: clock_correction expected %0d, actual %0d", $time,
                        want.correction, rsp_clock_correction);
               errors++;
            end
            if (rsp_offset_estimate !== want.offset) begin
               $display("%0t: offset_estimate expected %0d, actual %0d", $time,
                        want.offset, rsp_offset_estimate);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic logic [TIME_W-1:0] rand_time();
      logic [WORD_W-1:0] r;
      r = {$urandom, $urandom};
      return r[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] next_now();
      int pick;
      pick = $urandom_range(99);
      if (pick < 7) begin
         local_clock_ns = local_clock_ns - $urandom_range(32'hFFFF_FFFF, 1);
      end else if (pick < 12) begin
         local_clock_ns = local_clock_ns + (62'd1 << 47);
      end else if (pick >= 20) begin
         local_clock_ns = local_clock_ns + $urandom_range(2000000000, 1000000);
      end
      return local_clock_ns;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return GAIN_W'($urandom_range(4096));
      endcase
   endfunction

   // valid is left high after acceptance; the next call lowers it or drives the next word, and wait_idle lowers it
   task automatic send_item(input cmd_type cmd, input logic [TIME_W-1:0] master_ns,
                            input logic [TIME_W-1:0] slave_ns,
                            input logic [TIME_W-1:0] now_ns);
      int gap;
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(90, 10) : $urandom_range(6, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_master_time_ns <= master_ns;
      req_slave_time_ns  <= slave_ns;
      req_now_ns         <= now_ns;
      do @(posedge clock); while (!req_ready);
      servo_update(cmd, master_ns, slave_ns, now_ns);
      if (cmd != CMD_UNUSED) words_sent++;
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      register_write(idx, data);
   endtask

   task automatic apply_settings(input bit en, input int asym, input logic [GAIN_W-1:0] g0,
                                 input logic [GAIN_W-1:0] g1,
                                 input logic [GAIN_W-1:0] g2);
      csr_put(CSR_ENABLE, CSR_DATA_W'(en));
      csr_put(CSR_ASYM, CSR_DATA_W'(asym));
      csr_put(CSR_GAIN0, CSR_DATA_W'(g0));
      csr_put(CSR_GAIN1, CSR_DATA_W'(g1));
      csr_put(CSR_GAIN2, CSR_DATA_W'(g2));
      // unmapped index: must be ignored
      csr_put(CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // all results in, then room for a word that gives no result to finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_corrections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_default_path();
      send_item(CMD_SYNC, 62'd1000, 62'd1500, 62'd10);
      send_item(CMD_REQ_SENT, 62'd0, 62'd2000, 62'd20);
      send_item(CMD_RESPONSE, 62'd2400, 62'd0, 62'd30);
      send_item(CMD_UNUSED, TIME_MAX, TIME_MAX, TIME_MAX);
      send_item(CMD_RESPONSE, 62'd2400, TIME_MAX, 62'd0);
   endtask

   task automatic test_offset_saturation();
      send_item(CMD_SYNC, 62'd0, TIME_MAX, 62'd0);
      send_item(CMD_RESPONSE, 62'd0, 62'd0, 62'd0);
      send_item(CMD_SYNC, TIME_MAX, 62'd0, 62'd0);
      send_item(CMD_REQ_SENT, TIME_MAX, 62'd0, 62'd0);
      send_item(CMD_RESPONSE, TIME_MAX, 62'd0, TIME_MAX);
   endtask

   task automatic test_controller_edges();
      wait_idle();
      apply_settings(1'b1, 0, GAIN0_RST, GAIN1_RST, GAIN2_RST);
      send_item(CMD_SYNC, 62'd5000, 62'd6200, 62'd0);
      send_item(CMD_REQ_SENT, 62'd0, 62'd9000, 62'd0);
      send_item(CMD_RESPONSE, 62'd9800, 62'd0, 62'd1000000000);
      // local time running backwards
      send_item(CMD_RESPONSE, 62'd9800, 62'd0, 62'd400000000);
      // interval past 65536 s
      send_item(CMD_RESPONSE, 62'd9800, 62'd0, 62'd70000400000000);
      send_item(CMD_RESPONSE, 62'd9800, 62'd0, TIME_MAX);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      apply_settings(1'b1, ASYM_LIMIT, '1, '1, '1);
      send_item(CMD_SYNC, 62'd0, 62'd3000000, 62'd0);
      send_item(CMD_REQ_SENT, 62'd0, 62'd5000000, 62'd0);
      send_item(CMD_RESPONSE, 62'd5500000, 62'd0, 62'd3000000000);
      send_item(CMD_RESPONSE, 62'd5500000, 62'd0, 62'd5000000000);
      wait_idle();
      apply_settings(1'b0, -ASYM_LIMIT, '0, '0, '0);
      send_item(CMD_RESPONSE, 62'd5500000, 62'd0, 62'd6000000000);
      send_item(CMD_RESPONSE, 62'd4000000, 62'd0, 62'd7000000000);
   endtask

   task automatic random_exchange();
      logic [TIME_W-1:0] t1, t2, t3, t4;
      longint            path_ns, skew_ns;
      int                pick;
      pick    = $urandom_range(99);
      path_ns = $urandom_range(200000);
      case ($urandom_range(3))
         0:       skew_ns = longint'($urandom_range(2000)) - 1000;
         1:       skew_ns = longint'($urandom_range(1 << 21)) - (1 << 20);
         2:       skew_ns = $signed({$urandom, $urandom}) >>> 25;
         default: skew_ns = $signed({$urandom, $urandom}) >>> 12;  // offsets clip
      endcase
      t1 = rand_time() >> 2;
      t2 = TIME_W'(t1 + path_ns + skew_ns);
      t3 = t2 + $urandom_range(1000000, 1);
      t4 = TIME_W'(t3 + path_ns - skew_ns + $urandom_range(100));
      if (pick < 10) begin
         send_item(cmd_type'($urandom_range(3)), rand_time(), rand_time(), rand_time());
      end else if (pick < 25) begin
         // broken exchange: a step missing or repeated
         case ($urandom_range(2))
            0: send_item(CMD_RESPONSE, t4, rand_time(), next_now());
            1: begin
               send_item(CMD_SYNC, t1, t2, next_now());
               send_item(CMD_RESPONSE, t4, rand_time(), next_now());
            end
            default: begin
               send_item(CMD_REQ_SENT, rand_time(), t3, next_now());
               send_item(CMD_SYNC, t1, t2, next_now());
               send_item(CMD_SYNC, t2, t1, next_now());
            end
         endcase
      end else begin
         send_item(CMD_SYNC, t1, t2, next_now());
         send_item(CMD_REQ_SENT, rand_time(), t3, next_now());
         send_item(CMD_RESPONSE, t4, rand_time(), next_now());
      end
   endtask

   task automatic test_random_traffic();
      int  mode, setup, start, asym;
      bit  en;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin tx_idle_pct = 32; rx_stall_pct = 68; end
            1:       begin tx_idle_pct = 68; rx_stall_pct = 32; end
            default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
         endcase
         for (setup = 0; setup < 3; setup++) begin
            wait_idle();
            en = $urandom_range(1);
            case ($urandom_range(3))
               0:       asym = -ASYM_LIMIT;
               1:       asym = ASYM_LIMIT;
               default: asym = int'($urandom_range(2 * ASYM_LIMIT)) - ASYM_LIMIT;
            endcase
            apply_settings(en, asym, pick_gain(), pick_gain(), pick_gain());
            start = words_sent;
            while (words_sent - start < WORDS_PER_SETUP) random_exchange();
         end
      end
   endtask

   initial begin
      servo_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_default_path();
      test_offset_saturation();
      test_controller_edges();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      $display("Checked %0d servo results from %0d timestamp words over %0d register setups,",
               corrections_checked, words_sent, settings_applied);
      $display("both servo modes, stalls on either side in turn and then none.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
